// ----- sv/lpcm_byte_swap_channel_remap_assert.svh -----
// Assertion macros for the lpcm remap checker
`ifndef LPCM_BYTE_SWAP_CHANNEL_REMAP_ASSERT_SVH
`define LPCM_BYTE_SWAP_CHANNEL_REMAP_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset
`define LBSCR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset
`define LBSCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/lbscr_pkg.sv -----
// Package: types, constants and helpers of the lpcm byte swap channel remap block
package lbscr_pkg;

    localparam int MAX_CHANNELS_DEF     = 8;
    localparam int MAX_SAMPLE_BYTES_DEF = 3;

    localparam int POS_W   = 5;   // frame position counter width
    localparam int SLOT_W  = 3;   // output slot index width
    localparam int SRC_W   = 3;   // one channel map field
    localparam int ORDER_W = 24;  // eight map fields
    localparam int QDEPTH  = 4;   // job queue entries

    // Configuration register indexes
    localparam logic [1:0] CFG_SAMPLE_BYTES  = 2'd0;
    localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd1;
    localparam logic [1:0] CFG_CHANNEL_ORDER = 2'd2;

    localparam logic [1:0]         SAMPLE_BYTES_RST  = 2'd2;
    localparam logic [3:0]         CHANNEL_COUNT_RST = 4'd2;
    localparam logic [ORDER_W-1:0] CHANNEL_ORDER_RST = 24'hFAC688;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       end_of_packet;
    } t_in;

    typedef struct packed {
        logic [31:0] sample_word;
        logic        frame_last;
    } t_out;

    typedef struct packed {
        logic [1:0]         sample_bytes;
        logic [3:0]         channel_count;
        logic [ORDER_W-1:0] channel_order;
    } t_cfg;

    // One classified byte on its way to the back end
    typedef struct packed {
        logic [7:0]       data;
        logic [POS_W-1:0] pos;
        logic             wr;     // position lies inside the buffer
        logic             done;   // this byte completes a frame
    } t_job;

    // True when samples are 24-bit
    function automatic logic is_sb24(logic [1:0] sb, int max_sb);
        return (sb == 2'd3) && (max_sb >= 3);
    endfunction

    // Clamp the channel count to 1..max_ch
    function automatic logic [3:0] eff_ch(logic [3:0] ch, int max_ch);
        logic [3:0] r;
        r = ch;
        if (ch == 4'd0) begin
            r = 4'd1;
        end else if (int'(ch) > max_ch) begin
            r = 4'(max_ch);
        end
        return r;
    endfunction

    // Round the channel count up to even
    function automatic logic [3:0] pad_ch(logic [3:0] ch);
        return (ch + 4'd1) & 4'hE;
    endfunction

    // Frame length in bytes
    function automatic logic [POS_W-1:0] frame_len(logic [3:0] pad, logic sb24);
        return POS_W'({1'b0, pad} << 1) + (sb24 ? POS_W'(pad) : POS_W'(0));
    endfunction

endpackage

// ----- sv/lbscr_front.sv -----
// Front end: track frame position and classify each accepted payload byte
module lbscr_front #(
    parameter int MAX_CHANNELS     = lbscr_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_SAMPLE_BYTES = lbscr_pkg::MAX_SAMPLE_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lbscr_pkg::t_cfg   i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lbscr_pkg::t_in    i_in_data,
    input  logic              i_q_full,
    output logic              o_push,
    output lbscr_pkg::t_job   o_job
);
    localparam int PAD_CH    = (MAX_CHANNELS + 1) & 'hfe;
    localparam int BUF_BYTES = PAD_CH * MAX_SAMPLE_BYTES;

    logic [lbscr_pkg::POS_W-1:0] r_pos, n_pos, pos_inc, flen;
    logic [3:0]                  ch, pad;
    logic                        sb24, done;

    // Derive the frame length from the live configuration
    assign sb24 = lbscr_pkg::is_sb24(i_cfg.sample_bytes, MAX_SAMPLE_BYTES);
    assign ch   = lbscr_pkg::eff_ch(i_cfg.channel_count, MAX_CHANNELS);
    assign pad  = lbscr_pkg::pad_ch(ch);
    assign flen = lbscr_pkg::frame_len(pad, sb24);

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // Classify the byte: where it goes and whether it closes the frame
    assign pos_inc = r_pos + 1'b1;
    assign done    = pos_inc >= flen;

    always_comb begin
        o_job.data = i_in_data.payload_byte;
        o_job.pos  = r_pos;
        o_job.wr   = int'(r_pos) < BUF_BYTES;
        o_job.done = done;
        n_pos      = r_pos;
        if (o_push) begin
            n_pos = (done || i_in_data.end_of_packet) ? '0 : pos_inc;
        end
    end

    // Advance the position on each transfer, back to zero at frame end or end of packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

// ----- sv/lbscr_fifo.sv -----
// Job queue between the front end and the back end
module lbscr_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lbscr_pkg::t_job i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output lbscr_pkg::t_job o_job
);
    localparam int PTR_W = $clog2(lbscr_pkg::QDEPTH);

    lbscr_pkg::t_job  r_slot [lbscr_pkg::QDEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [PTR_W:0]   r_cnt;
    logic             do_push, do_pop;

    assign o_full  = r_cnt == (PTR_W+1)'(lbscr_pkg::QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_slot[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store the pushed job
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_job;
        end
    end

    // Move the pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- sv/lbscr_back.sv -----
// Back end: frame buffer, per-slot sample gather and the output register
module lbscr_back #(
    parameter int MAX_CHANNELS     = lbscr_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_SAMPLE_BYTES = lbscr_pkg::MAX_SAMPLE_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lbscr_pkg::t_cfg   i_cfg,
    input  logic              i_job_valid,
    input  lbscr_pkg::t_job   i_job,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output lbscr_pkg::t_out   o_out_data
);
    localparam int PAD_CH    = (MAX_CHANNELS + 1) & 'hfe;
    localparam int BUF_BYTES = PAD_CH * MAX_SAMPLE_BYTES;
    localparam int IDX_W     = $clog2(BUF_BYTES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_LAST  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [7:0]                   r_frame_mem [BUF_BYTES];
    logic [7:0]                   r_rdata;
    logic [2:0]                   r_state, n_state;
    logic [lbscr_pkg::SLOT_W-1:0] r_slot, n_slot;
    logic [IDX_W-1:0]             r_addr, n_addr;
    logic [1:0]                   r_left, n_left;
    logic                         r_pend, n_pend;
    logic [23:0]                  r_acc, n_acc;
    logic                         r_ovalid, n_ovalid;
    lbscr_pkg::t_out              r_out, n_out;

    logic                         sb24, out_free, last;
    logic [3:0]                   ch, pad;
    logic [lbscr_pkg::SRC_W-1:0]  src;
    logic [lbscr_pkg::POS_W-1:0]  base;
    logic [31:0]                  word;

    assign sb24 = lbscr_pkg::is_sb24(i_cfg.sample_bytes, MAX_SAMPLE_BYTES);
    assign ch   = lbscr_pkg::eff_ch(i_cfg.channel_count, MAX_CHANNELS);
    assign pad  = lbscr_pkg::pad_ch(ch);

    // Pick the source channel of the current slot and its first byte
    assign src  = i_cfg.channel_order[lbscr_pkg::SRC_W*r_slot +: lbscr_pkg::SRC_W];
    assign base = lbscr_pkg::POS_W'({2'b0, src} << 1)
                + (sb24 ? lbscr_pkg::POS_W'(src) : lbscr_pkg::POS_W'(0));
    assign last = ({1'b0, r_slot} + 4'd1) == ch;

    // Swap 16-bit samples into the low half, left-align 24-bit ones
    assign word = sb24 ? {r_acc, 8'h00} : {16'h0000, r_acc[15:0]};

    assign out_free    = !r_ovalid || i_out_ready;
    assign o_pop       = (r_state == S_IDLE) && i_job_valid;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    // Frame buffer: write from the queue, registered read for the gather
    always_ff @(posedge i_clk) begin
        if (o_pop && i_job.wr) begin
            r_frame_mem[i_job.pos[IDX_W-1:0]] <= i_job.data;
        end
        r_rdata <= r_frame_mem[r_addr];
    end

    always_comb begin
        n_state  = r_state;
        n_slot   = r_slot;
        n_addr   = r_addr;
        n_left   = r_left;
        n_pend   = r_pend;
        n_acc    = r_acc;
        n_out    = r_out;
        n_ovalid = r_ovalid && !i_out_ready;
        case (r_state)
            // Take the next byte; start output on a finished frame
            S_IDLE: begin
                if (i_job_valid && i_job.done) begin
                    n_slot  = '0;
                    n_state = S_SETUP;
                end
            end
            // Resolve the slot: zero for an unmapped source, else gather bytes
            S_SETUP: begin
                n_acc  = '0;
                n_pend = 1'b0;
                if ({1'b0, src} >= pad) begin
                    n_state = S_EMIT;
                end else begin
                    n_addr  = base[IDX_W-1:0];
                    n_left  = sb24 ? 2'd3 : 2'd2;
                    n_state = S_READ;
                end
            end
            // Issue one address a cycle, shift in the byte read before
            S_READ: begin
                n_pend = 1'b1;
                n_left = r_left - 2'd1;
                if (r_pend) begin
                    n_acc = {r_acc[15:0], r_rdata};
                end
                if (r_left == 2'd1) begin
                    n_state = S_LAST;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            // Shift in the final byte
            S_LAST: begin
                n_acc   = {r_acc[15:0], r_rdata};
                n_state = S_EMIT;
            end
            // Load the output register once it is free
            S_EMIT: begin
                if (out_free) begin
                    n_out.sample_word = word;
                    n_out.frame_last  = last;
                    n_ovalid          = 1'b1;
                    n_slot            = r_slot + 1'b1;
                    n_state           = last ? S_IDLE : S_SETUP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold payload without reset
    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_left <= n_left;
        r_pend <= n_pend;
        r_acc  <= n_acc;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_slot   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_slot   <= n_slot;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

// ----- sv/lpcm_byte_swap_channel_remap.sv -----
// Top level: big-endian LPCM frames in, remapped host sample words out
//
// Input channel: one payload byte per transfer with an end-of-packet flag.
// Bytes are collected into a frame of (channel count rounded up to even)
// times 2 or 3 bytes. On the byte that completes a frame, one sample word
// per real channel goes out, slot i taking the source channel named by
// map field i; frame_last marks the final sample of the frame.
// Configuration channel: register index and data, always ready; write it
// only while no frame is in flight.
// Throughput: non-completing bytes are taken one per cycle while the queue
// has room. Output of a frame is gathered one buffer byte per cycle through
// the single read port of the frame buffer; each mapped sample passes setup,
// read, last-byte and emit steps, and a sample whose source lies past the
// padded count goes from setup straight to emit as zero.
// A four-entry job queue sits between the byte side and the output side,
// so input keeps flowing while the output gather runs, until the queue fills.
// When the receiver stalls the output register holds its word and the
// gather waits; once the queue is full the input ready drops.
// Reset clears the frame position, the queue and the output valid, and
// loads the default configuration (16-bit, two channels, identity map).
module lpcm_byte_swap_channel_remap #(
    parameter int MAX_CHANNELS     = lbscr_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_SAMPLE_BYTES = lbscr_pkg::MAX_SAMPLE_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  lbscr_pkg::t_in                    i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output lbscr_pkg::t_out                   o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [1:0]                        i_cfg_index,
    input  logic [lbscr_pkg::ORDER_W-1:0]     i_cfg_data
);
    lbscr_pkg::t_cfg r_cfg;
    lbscr_pkg::t_job push_job, head_job;
    logic            q_full, push, pop, head_valid;

    assign o_cfg_ready = 1'b1;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_bytes  <= lbscr_pkg::SAMPLE_BYTES_RST;
            r_cfg.channel_count <= lbscr_pkg::CHANNEL_COUNT_RST;
            r_cfg.channel_order <= lbscr_pkg::CHANNEL_ORDER_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lbscr_pkg::CFG_SAMPLE_BYTES:  r_cfg.sample_bytes  <= i_cfg_data[1:0];
                lbscr_pkg::CFG_CHANNEL_COUNT: r_cfg.channel_count <= i_cfg_data[3:0];
                lbscr_pkg::CFG_CHANNEL_ORDER: r_cfg.channel_order <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    lbscr_front #(
        .MAX_CHANNELS     (MAX_CHANNELS),
        .MAX_SAMPLE_BYTES (MAX_SAMPLE_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (push_job)
    );

    lbscr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_job   (head_job)
    );

    lbscr_back #(
        .MAX_CHANNELS     (MAX_CHANNELS),
        .MAX_SAMPLE_BYTES (MAX_SAMPLE_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (head_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- sv/lbscr_checker.sv -----
// Port-level checker for the lpcm remap block, bound to the top level
`include "lpcm_byte_swap_channel_remap_assert.svh"

module lbscr_checker #(
    parameter int MAX_SAMPLE_BYTES = lbscr_pkg::MAX_SAMPLE_BYTES_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input lbscr_pkg::t_in                i_in_data,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input lbscr_pkg::t_out               o_out_data,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready,
    input logic [1:0]                    i_cfg_index,
    input logic [lbscr_pkg::ORDER_W-1:0] i_cfg_data
);
    logic [1:0] r_sb;
    logic [3:0] r_ch;
    logic       sb24, single;

    // Shadow the sample size and channel count from configuration transfers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sb <= lbscr_pkg::SAMPLE_BYTES_RST;
            r_ch <= lbscr_pkg::CHANNEL_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == lbscr_pkg::CFG_SAMPLE_BYTES) begin
                r_sb <= i_cfg_data[1:0];
            end
            if (i_cfg_index == lbscr_pkg::CFG_CHANNEL_COUNT) begin
                r_ch <= i_cfg_data[3:0];
            end
        end
    end

    assign sb24   = lbscr_pkg::is_sb24(r_sb, MAX_SAMPLE_BYTES);
    assign single = r_ch <= 4'd1;

    // A stalled result holds
    `LBSCR_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out_data), "output changed while stalled")

    // 16-bit samples occupy only the low half
    `LBSCR_ASSERT_NOW(a_sb16_high_zero, o_out_valid && !sb24,
        o_out_data.sample_word[31:16] == 16'h0000, "16-bit sample has high bits")

    // 24-bit samples are left-aligned
    `LBSCR_ASSERT_NOW(a_sb24_low_zero, o_out_valid && sb24,
        o_out_data.sample_word[7:0] == 8'h00, "24-bit sample not left-aligned")

    // With one channel every sample closes its frame
    `LBSCR_ASSERT_NOW(a_single_last, o_out_valid && single,
        o_out_data.frame_last, "single-channel sample without frame_last")

endmodule

bind lpcm_byte_swap_channel_remap lbscr_checker #(
    .MAX_SAMPLE_BYTES (MAX_SAMPLE_BYTES)
) u_lbscr_checker (.*);
